### design/hssd_pkg.sv
// Package: types, command codes, register indexes and the half-step coil table.
`timescale 1ns / 1ps

package hssd_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;

   localparam int COMMAND_BITS = 2;
   localparam int LEVEL_BITS   = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int COILS_BITS   = 4;
   localparam int REPORT_BITS  = 16;

   localparam int SHIFT_BITS  = 4;
   localparam int THRESH_BITS = 10;
   localparam int JOG_BITS    = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [COMMAND_BITS-1:0] CMD_TICK   = 2'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_SET    = 2'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_CLOSE  = 2'd2;
   localparam logic [COMMAND_BITS-1:0] CMD_SAMPLE = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_SHIFT     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LARGE_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMALL_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_JOG_DISTANCE    = 2'd3;

   localparam logic [SHIFT_BITS-1:0]  SCALE_SHIFT_RESET     = 4'd5;
   localparam logic [THRESH_BITS-1:0] LARGE_THRESHOLD_RESET = 10'd500;
   localparam logic [THRESH_BITS-1:0] SMALL_THRESHOLD_RESET = 10'd100;
   localparam logic [JOG_BITS-1:0]    JOG_DISTANCE_RESET    = 16'd1024;

   typedef struct packed {
      logic [COMMAND_BITS-1:0] command;
      logic [LEVEL_BITS-1:0]   level;
      logic [SAMPLE_BITS-1:0]  sample;
   } req_item_type;

   typedef struct packed {
      logic [COILS_BITS-1:0]  coils;
      logic [REPORT_BITS-1:0] position;
      logic [REPORT_BITS-1:0] brightness;
      logic                   is_open;
      logic                   moving;
      logic                   report;
   } rsp_item_type;

   typedef struct packed {
      logic [SHIFT_BITS-1:0]  scale_shift;
      logic [THRESH_BITS-1:0] large_threshold;
      logic [THRESH_BITS-1:0] small_threshold;
      logic [JOG_BITS-1:0]    jog_distance;
   } cfg_type;

   // Eight-phase half-step sequence, indexed by position mod 8.
   function automatic logic [COILS_BITS-1:0] half_step_coils(input logic [2:0] phase);
      logic [COILS_BITS-1:0] pattern;
      unique case (phase)
         3'd0: pattern = 4'h1;
         3'd1: pattern = 4'h3;
         3'd2: pattern = 4'h2;
         3'd3: pattern = 4'h6;
         3'd4: pattern = 4'h4;
         3'd5: pattern = 4'hC;
         3'd6: pattern = 4'h8;
         3'd7: pattern = 4'h9;
         default: pattern = 4'h0;
      endcase
      return pattern;
   endfunction

endpackage

### design/hssd_csr.sv
// Configuration registers written through the plain write port.
`timescale 1ns / 1ps

module hssd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [hssd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [hssd_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output hssd_pkg::cfg_type                      cfg
);

   hssd_pkg::cfg_type cfg_ff;
   hssd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            hssd_pkg::CSR_SCALE_SHIFT:
               cfg_in.scale_shift = csr_wdata[hssd_pkg::SHIFT_BITS-1:0];
            hssd_pkg::CSR_LARGE_THRESHOLD:
               cfg_in.large_threshold = csr_wdata[hssd_pkg::THRESH_BITS-1:0];
            hssd_pkg::CSR_SMALL_THRESHOLD:
               cfg_in.small_threshold = csr_wdata[hssd_pkg::THRESH_BITS-1:0];
            hssd_pkg::CSR_JOG_DISTANCE:
               cfg_in.jog_distance = csr_wdata[hssd_pkg::JOG_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_shift     <= hssd_pkg::SCALE_SHIFT_RESET;
         cfg_ff.large_threshold <= hssd_pkg::LARGE_THRESHOLD_RESET;
         cfg_ff.small_threshold <= hssd_pkg::SMALL_THRESHOLD_RESET;
         cfg_ff.jog_distance    <= hssd_pkg::JOG_DISTANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/hssd_datapath.sv
// Combinational next state and result for one item.
`timescale 1ns / 1ps

module hssd_datapath #(
   parameter int POSITION_BITS = hssd_pkg::POSITION_BITS_DEFAULT
) (
   input  hssd_pkg::req_item_type                 item,
   input  hssd_pkg::cfg_type                      cfg,
   input  logic [POSITION_BITS-1:0]               step_cur,
   input  logic [POSITION_BITS-1:0]               target_cur,
   input  logic [hssd_pkg::SAMPLE_BITS-1:0]       last_sample_cur,
   input  logic                                   sample_seen_cur,
   output logic [POSITION_BITS-1:0]               step_next,
   output logic [POSITION_BITS-1:0]               target_next,
   output logic [hssd_pkg::SAMPLE_BITS-1:0]       last_sample_next,
   output logic                                   sample_seen_next,
   output hssd_pkg::rsp_item_type                 result
);

   localparam int SHIFT_MAX = (1 << hssd_pkg::SHIFT_BITS) - 1;
   localparam int SET_BITS  = hssd_pkg::LEVEL_BITS + SHIFT_MAX;
   localparam int WIDE_BITS = (POSITION_BITS > SET_BITS) ? POSITION_BITS : SET_BITS;
   localparam int JOG_SUM_BITS =
      ((POSITION_BITS > hssd_pkg::JOG_BITS) ? POSITION_BITS : hssd_pkg::JOG_BITS) + 1;
   localparam int DIFF_BITS = hssd_pkg::SAMPLE_BITS + 2;
   localparam int BRIGHT_BITS = POSITION_BITS + 1;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [BRIGHT_BITS-1:0] BRIGHT_MAX =
      BRIGHT_BITS'({hssd_pkg::REPORT_BITS{1'b1}});

   logic [WIDE_BITS-1:0]     set_wide;
   logic [POSITION_BITS-1:0] set_target;
   logic [JOG_SUM_BITS-1:0]  target_ext;
   logic [JOG_SUM_BITS-1:0]  jog_ext;
   logic [JOG_SUM_BITS-1:0]  up_sum;
   logic [POSITION_BITS-1:0] jog_up_target;
   logic [POSITION_BITS-1:0] jog_down_target;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [DIFF_BITS-1:0] large_s;
   logic signed [DIFF_BITS-1:0] small_s;
   logic [POSITION_BITS-1:0] frac_mask;
   logic [BRIGHT_BITS-1:0]   bright_raw;
   logic [hssd_pkg::COILS_BITS-1:0] coils;
   logic report;

   // Set level: level shifted by the scale, clamped to the top of the range.
   always_comb begin
      set_wide = WIDE_BITS'(item.level) << cfg.scale_shift;
      if (set_wide > WIDE_BITS'(POS_MAX)) begin
         set_target = POS_MAX;
      end else begin
         set_target = set_wide[POSITION_BITS-1:0];
      end
   end

   // Jog arithmetic with saturation at both ends of the position range.
   always_comb begin
      target_ext = JOG_SUM_BITS'(target_cur);
      jog_ext    = JOG_SUM_BITS'(cfg.jog_distance);
      up_sum     = target_ext + jog_ext;
      if (up_sum > JOG_SUM_BITS'(POS_MAX)) begin
         jog_up_target = POS_MAX;
      end else begin
         jog_up_target = up_sum[POSITION_BITS-1:0];
      end
      if (target_ext > jog_ext) begin
         jog_down_target = POSITION_BITS'(target_ext - jog_ext);
      end else begin
         jog_down_target = '0;
      end
   end

   assign diff    = $signed(DIFF_BITS'(item.sample)) - $signed(DIFF_BITS'(last_sample_cur));
   assign large_s = $signed(DIFF_BITS'(cfg.large_threshold));
   assign small_s = $signed(DIFF_BITS'(cfg.small_threshold));

   always_comb begin
      step_next        = step_cur;
      target_next      = target_cur;
      last_sample_next = last_sample_cur;
      sample_seen_next = sample_seen_cur;
      coils            = '0;
      report           = 1'b0;
      unique case (item.command)
         hssd_pkg::CMD_TICK: begin
            if (step_cur != target_cur) begin
               coils = hssd_pkg::half_step_coils(step_cur[2:0]);
               if (target_cur > step_cur) begin
                  step_next = step_cur + POSITION_BITS'(1);
               end else begin
                  step_next = step_cur - POSITION_BITS'(1);
               end
               report = (step_next == target_cur);
            end
         end
         hssd_pkg::CMD_SET: begin
            if (item.level != '0) begin
               target_next = set_target;
            end
            report = 1'b1;
         end
         hssd_pkg::CMD_CLOSE: begin
            target_next = '0;
            report      = 1'b1;
         end
         hssd_pkg::CMD_SAMPLE: begin
            last_sample_next = item.sample;
            sample_seen_next = 1'b1;
            // The first sample after reset only primes the comparison.
            if (sample_seen_cur) begin
               priority if (diff >= large_s) begin
                  target_next = jog_up_target;
                  report      = 1'b1;
               end else if (diff <= -large_s) begin
                  target_next = jog_down_target;
                  report      = 1'b1;
               end else if (diff <= -small_s) begin
                  target_next = jog_up_target;
                  report      = 1'b1;
               end else if (diff >= small_s) begin
                  target_next = jog_down_target;
                  report      = 1'b1;
               end
            end
         end
         default: report = 1'b0;
      endcase
   end

   // Brightness is the position over the scale, rounded up, at least one.
   always_comb begin
      frac_mask  = ~({POSITION_BITS{1'b1}} << cfg.scale_shift);
      bright_raw = BRIGHT_BITS'(step_next >> cfg.scale_shift)
                 + BRIGHT_BITS'(|(step_next & frac_mask));
      if (bright_raw == '0) begin
         bright_raw = BRIGHT_BITS'(1);
      end else if (bright_raw > BRIGHT_MAX) begin
         bright_raw = BRIGHT_MAX;
      end
   end

   always_comb begin
      result.coils      = coils;
      result.position   = hssd_pkg::REPORT_BITS'(step_next);
      result.brightness = hssd_pkg::REPORT_BITS'(bright_raw);
      result.is_open    = (step_next != '0);
      result.moving     = (step_next != target_next);
      result.report     = report;
   end

endmodule

### design/half_step_stepper_position_driver_core.sv
// Top level of the half-step stepper position driver.
`timescale 1ns / 1ps
// An accepted item waits in the input register; its result enters the output register
// when that register is empty or being emptied. Throughput: one item per cycle while
// results are taken; position and target registers update in one pass.
// While a result waits, the input register takes one more item, then the input stalls.
// Reset (synchronous, active high) clears position, target, last sample, the sample
// flag and both valid bits, and loads the configuration defaults.

module half_step_stepper_position_driver_core #(
   parameter int POSITION_BITS = hssd_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hssd_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hssd_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_we,
   input  logic [hssd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hssd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   hssd_pkg::cfg_type cfg;

   // Input register: holds the accepted item until the datapath consumes it.
   hssd_pkg::req_item_type req_ff;
   logic                   req_valid_ff;

   // Motor state, advanced once per item as it passes into the output register.
   logic [POSITION_BITS-1:0]         step_ff;
   logic [POSITION_BITS-1:0]         step_in;
   logic [POSITION_BITS-1:0]         target_ff;
   logic [POSITION_BITS-1:0]         target_in;
   logic [hssd_pkg::SAMPLE_BITS-1:0] last_sample_ff;
   logic [hssd_pkg::SAMPLE_BITS-1:0] last_sample_in;
   logic                             sample_seen_ff;
   logic                             sample_seen_in;

   // Output register.
   hssd_pkg::rsp_item_type rsp_ff;
   hssd_pkg::rsp_item_type rsp_in;
   logic                   rsp_valid_ff;

   logic advance;

   hssd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hssd_datapath #(
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .item             (req_ff),
      .cfg              (cfg),
      .step_cur         (step_ff),
      .target_cur       (target_ff),
      .last_sample_cur  (last_sample_ff),
      .sample_seen_cur  (sample_seen_ff),
      .step_next        (step_in),
      .target_next      (target_in),
      .last_sample_next (last_sample_in),
      .sample_seen_next (sample_seen_in),
      .result           (rsp_in)
   );

   // The held item moves on when the output register is empty or being emptied.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   // A new item is taken whenever the input register is free or moving on this cycle.
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= '0;
         target_ff      <= '0;
         last_sample_ff <= '0;
         sample_seen_ff <= 1'b0;
      end else if (advance) begin
         step_ff        <= step_in;
         target_ff      <= target_in;
         last_sample_ff <= last_sample_in;
         sample_seen_ff <= sample_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### tb/sv/tb_half_step_stepper_position_driver_core.sv
// Self-checking testbench for the half-step stepper position driver core.
`timescale 1ns / 1ps

module tb_half_step_stepper_position_driver_core;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 10;
   // Settling margin; every item yields one result, so this only guards against
   // a late or extra result after the queue drains.
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 200;

   localparam int          POS_BITS = hssd_pkg::POSITION_BITS_DEFAULT;
   localparam int unsigned POS_MAX  = (32'd1 << POS_BITS) - 32'd1;

   // Coil drive for each phase of the eight-phase half-step sequence.
   localparam logic [hssd_pkg::COILS_BITS-1:0] HALF_STEP_COILS [0:7] = '{
      4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
   };

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   hssd_pkg::req_item_type              req_data;
   logic                                rsp_valid;
   logic                                rsp_ready;
   hssd_pkg::rsp_item_type              rsp_data;
   logic                                csr_we;
   logic [hssd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [hssd_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   // Our own copy of the motor state and of the registers it depends on.
   int unsigned                      motor_pos     = 0;
   int unsigned                      motor_target  = 0;
   logic [hssd_pkg::SAMPLE_BITS-1:0] prev_sample   = '0;
   logic                             sample_stored = 1'b0;
   logic [hssd_pkg::SHIFT_BITS-1:0]  cfg_shift;
   logic [hssd_pkg::THRESH_BITS-1:0] cfg_large;
   logic [hssd_pkg::THRESH_BITS-1:0] cfg_small;
   logic [hssd_pkg::JOG_BITS-1:0]    cfg_jog;

   hssd_pkg::rsp_item_type expected_status_q[$];

   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_gap_pct   = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned hold_seq       = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;

   half_step_stepper_position_driver_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Watchdog: a run that hangs on a handshake ends here as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_half_step_stepper_position_driver_core failed");
         $finish;
      end
   end

   // Target after one encoder detent upward; it saturates at the top of the
   // position range.
   function automatic int unsigned jogged_up(input int unsigned target);
      int unsigned sum;
      sum = target + cfg_jog;
      return (sum > POS_MAX) ? POS_MAX : sum;
   endfunction

   // Target after one encoder detent downward; it saturates at zero.
   function automatic int unsigned jogged_down(input int unsigned target);
      return (target > cfg_jog) ? target - cfg_jog : 32'd0;
   endfunction

   // Advances the motor state by one accepted item and returns the status
   // item that the block must report for it.
   task automatic predict_status(input hssd_pkg::req_item_type item,
                                 output hssd_pkg::rsp_item_type status);
      int unsigned level_target;
      int unsigned bright;
      int          delta;
      int          large_th;
      int          small_th;
      logic [hssd_pkg::COILS_BITS-1:0] coil_drive;
      logic        due;
      coil_drive = '0;
      due = 1'b0;
      case (item.command)
         hssd_pkg::CMD_TICK: begin
            // The coils show the phase being left, then the position moves.
            if (motor_pos != motor_target) begin
               coil_drive = HALF_STEP_COILS[motor_pos[2:0]];
               if (motor_target > motor_pos) begin
                  motor_pos = motor_pos + 1;
               end else begin
                  motor_pos = motor_pos - 1;
               end
               due = (motor_pos == motor_target);
            end
         end
         hssd_pkg::CMD_SET: begin
            // Level zero leaves the target where it is but still reports.
            if (item.level != '0) begin
               level_target = 32'(item.level) << cfg_shift;
               motor_target = (level_target > POS_MAX) ? POS_MAX : level_target;
            end
            due = 1'b1;
         end
         hssd_pkg::CMD_CLOSE: begin
            motor_target = 0;
            due = 1'b1;
         end
         default: begin
            // The very first sample after reset is only stored.
            if (!sample_stored) begin
               sample_stored = 1'b1;
            end else begin
               delta    = int'(item.sample) - int'(prev_sample);
               large_th = int'(cfg_large);
               small_th = int'(cfg_small);
               // A large step means the encoder wrapped, so the sense flips.
               if (delta >= large_th) begin
                  motor_target = jogged_up(motor_target);
                  due = 1'b1;
               end else if (delta <= -large_th) begin
                  motor_target = jogged_down(motor_target);
                  due = 1'b1;
               end else if (delta <= -small_th) begin
                  motor_target = jogged_up(motor_target);
                  due = 1'b1;
               end else if (delta >= small_th) begin
                  motor_target = jogged_down(motor_target);
                  due = 1'b1;
               end
            end
            prev_sample = item.sample;
         end
      endcase
      bright = (motor_pos >> cfg_shift) +
               (((motor_pos & ((32'd1 << cfg_shift) - 32'd1)) != 0) ? 32'd1 : 32'd0);
      if (bright < 1) bright = 1;
      if (bright > 32'hFFFF) bright = 32'hFFFF;
      status.coils      = coil_drive;
      status.position   = hssd_pkg::REPORT_BITS'(motor_pos);
      status.brightness = hssd_pkg::REPORT_BITS'(bright);
      status.is_open    = (motor_pos > 0);
      status.moving     = (motor_pos != motor_target);
      status.report     = due;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Scoreboard. Both channels are sampled at the rising edge, before any
   // register in the block or in this testbench changes, so an accepted
   // item is seen exactly once.
   always @(posedge clock) begin
      hssd_pkg::rsp_item_type status;
      hssd_pkg::rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_status(req_data, status);
            expected_status_q.push_back(status);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               $error("unexpected result item: %p", rsp_data);
               error_count++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("coils", 16'(want.coils), 16'(rsp_data.coils));
               check_field("position", want.position, rsp_data.position);
               check_field("brightness", want.brightness, rsp_data.brightness);
               check_field("is_open", 16'(want.is_open), 16'(rsp_data.is_open));
               check_field("moving", 16'(want.moving), 16'(rsp_data.moving));
               check_field("report", 16'(want.report), 16'(rsp_data.report));
            end
         end
      end
   end

   // Result side. A long hold-off, when one is asked for, is counted down
   // here; otherwise ready drops at random with the current stall rate.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offers one item and returns at the edge where it is accepted. Before the
   // item is offered, each cycle is idle with the current gap rate; valid
   // stays high into the next item when no idle cycle is drawn.
   task automatic send_item(input hssd_pkg::req_item_type item);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic hssd_pkg::req_item_type make_item(
         input logic [hssd_pkg::COMMAND_BITS-1:0] command,
         input logic [hssd_pkg::LEVEL_BITS-1:0]   level,
         input logic [hssd_pkg::SAMPLE_BITS-1:0]  sample);
      hssd_pkg::req_item_type item;
      item.command = command;
      item.level   = level;
      item.sample  = sample;
      return item;
   endfunction

   // Mostly ticks, so the motor actually walks to its targets; levels are
   // mostly small so that the walks finish and the move-finished report shows.
   function automatic hssd_pkg::req_item_type random_command();
      hssd_pkg::req_item_type item;
      int unsigned            pick;
      pick = $urandom_range(99);
      item.level  = ($urandom_range(3) == 0) ? hssd_pkg::LEVEL_BITS'($urandom_range(255))
                                             : hssd_pkg::LEVEL_BITS'($urandom_range(15));
      item.sample = hssd_pkg::SAMPLE_BITS'($urandom_range(1023));
      if (pick < 55) begin
         item.command = hssd_pkg::CMD_TICK;
      end else if (pick < 70) begin
         item.command = hssd_pkg::CMD_SET;
      end else if (pick < 76) begin
         item.command = hssd_pkg::CMD_CLOSE;
      end else begin
         item.command = hssd_pkg::CMD_SAMPLE;
      end
      return item;
   endfunction

   // Stops offering items and waits until every expected result is in, then
   // lets the block settle before anything else, such as a register write.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers, one per cycle; only called while idle.
   task automatic set_config(input logic [hssd_pkg::SHIFT_BITS-1:0]  shift,
                             input logic [hssd_pkg::THRESH_BITS-1:0] large_th,
                             input logic [hssd_pkg::THRESH_BITS-1:0] small_th,
                             input logic [hssd_pkg::JOG_BITS-1:0]    jog);
      csr_we    <= 1'b1;
      csr_index <= hssd_pkg::CSR_SCALE_SHIFT;
      csr_wdata <= hssd_pkg::CSR_DATA_BITS'(shift);
      @(posedge clock);
      csr_index <= hssd_pkg::CSR_LARGE_THRESHOLD;
      csr_wdata <= hssd_pkg::CSR_DATA_BITS'(large_th);
      @(posedge clock);
      csr_index <= hssd_pkg::CSR_SMALL_THRESHOLD;
      csr_wdata <= hssd_pkg::CSR_DATA_BITS'(small_th);
      @(posedge clock);
      csr_index <= hssd_pkg::CSR_JOG_DISTANCE;
      csr_wdata <= hssd_pkg::CSR_DATA_BITS'(jog);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_shift = shift;
      cfg_large = large_th;
      cfg_small = small_th;
      cfg_jog   = jog;
   endtask

   // Hand-picked items: the extremes of every field, all four commands and
   // the corner cases of ticking, setting and encoder jogging.
   task automatic test_directed_extremes();
      // Reset configuration: shift 5, thresholds 500 and 100, jog 1024.
      send_item(make_item(hssd_pkg::CMD_TICK, 8'd0, 10'd0));       // tick while at target
      send_item(make_item(hssd_pkg::CMD_SET, 8'd0, 10'd1023));     // level zero keeps target
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd255, 10'd512)); // first sample is stored
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd1023));  // large rise: jog up
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd0));     // large fall: jog down
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd99));    // below small threshold
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd0));     // below small threshold
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd100));   // detent down, clamps at 0
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd0));     // detent up
      send_item(make_item(hssd_pkg::CMD_CLOSE, 8'd255, 10'd1023));
      wait_until_drained();

      // Widest scaling, extreme thresholds and the largest jog.
      set_config(4'd8, 10'd1023, 10'd1, 16'hFFFF);
      send_item(make_item(hssd_pkg::CMD_SET, 8'd255, 10'd0));
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd1023));  // jog up saturates at top
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd0));     // jog down saturates at 0
      wait_until_drained();

      // One step per level unit: a short walk up, a finished move, a tick at
      // rest, and the walk back down after close.
      set_config(4'd0, 10'd1, 10'd1, 16'd0);
      send_item(make_item(hssd_pkg::CMD_SET, 8'd3, 10'd0));
      repeat (4) send_item(make_item(hssd_pkg::CMD_TICK, 8'd0, 10'd0));
      send_item(make_item(hssd_pkg::CMD_CLOSE, 8'd0, 10'd0));
      repeat (3) send_item(make_item(hssd_pkg::CMD_TICK, 8'd0, 10'd0));
      wait_until_drained();

      // Register values past their normal range are used as written: a shift
      // of 15 pushes the set target past the top, and zero thresholds match
      // any difference.
      set_config(4'd15, 10'd0, 10'd0, 16'hFFFF);
      send_item(make_item(hssd_pkg::CMD_SET, 8'd255, 10'd0));
      send_item(make_item(hssd_pkg::CMD_SAMPLE, 8'd0, 10'd1023));
      send_item(make_item(hssd_pkg::CMD_TICK, 8'd0, 10'd0));
      wait_until_drained();
   endtask

   // One phase of random traffic under a given configuration and idling mix.
   task automatic test_random_traffic(input int unsigned sender_gap,
                                      input int unsigned receiver_stall,
                                      input int unsigned count,
                                      input logic [hssd_pkg::SHIFT_BITS-1:0]  shift,
                                      input logic [hssd_pkg::THRESH_BITS-1:0] large_th,
                                      input logic [hssd_pkg::THRESH_BITS-1:0] small_th,
                                      input logic [hssd_pkg::JOG_BITS-1:0]    jog);
      wait_until_drained();
      set_config(shift, large_th, small_th, jog);
      send_gap_pct  = sender_gap;
      rsp_stall_pct = receiver_stall;
      repeat (count) send_item(random_command());
      wait_until_drained();
   endtask

   // The result side holds off for a long stretch while items keep coming,
   // so both internal registers fill and the input stalls; afterwards the
   // sender pauses until everything has drained.
   task automatic test_backpressure();
      wait_until_drained();
      set_config(hssd_pkg::SCALE_SHIFT_RESET, hssd_pkg::LARGE_THRESHOLD_RESET,
                 hssd_pkg::SMALL_THRESHOLD_RESET, hssd_pkg::JOG_DISTANCE_RESET);
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      hold_seq++;
      repeat (24) send_item(random_command());
      wait_until_drained();
   endtask

   initial begin
      // Every input is known from time zero; reset is asserted first.
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = hssd_pkg::CSR_SCALE_SHIFT;
      csr_wdata = '0;

      cfg_shift = hssd_pkg::SCALE_SHIFT_RESET;
      cfg_large = hssd_pkg::LARGE_THRESHOLD_RESET;
      cfg_small = hssd_pkg::SMALL_THRESHOLD_RESET;
      cfg_jog   = hssd_pkg::JOG_DISTANCE_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();

      // Sender rarely idles, receiver often stalls; fine scaling, tight
      // detent threshold and small jogs keep targets reachable.
      test_random_traffic(6, 64, 140, 4'd0, 10'd1023, 10'd1, 16'd3);

      // Receiver rarely stalls, sender often idles; random thresholds.
      test_random_traffic(64, 6, 140, 4'd2, 10'($urandom_range(1023, 300)),
                          10'($urandom_range(299, 1)), 16'($urandom_range(8, 1)));

      // No idling on either side; a large threshold below the small one and
      // the widest jog.
      test_random_traffic(0, 0, 140, 4'd1, 10'd1, 10'd1023, 16'hFFFF);

      test_backpressure();

      wait_until_drained();
      if (error_count == 0) begin
         $display("tb_half_step_stepper_position_driver_core passed");
      end else begin
         $display("tb_half_step_stepper_position_driver_core failed");
      end
      $finish;
   end

endmodule
